// ===== rtl/core/first_fit_heap_allocator_defines.svh =====
// assertion macros for the first fit heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("first_fit_heap_allocator: same-cycle check failed");

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("first_fit_heap_allocator: next-cycle check failed");

`endif

// ===== rtl/core/ffha_pkg.sv =====
// shared constants and types for the first fit heap allocator
`timescale 1ns / 1ps

package ffha_pkg;

   localparam int HEAP_GRANULES_DEF   = 1024;
   localparam int HEADER_GRANULES_DEF = 2;

   localparam int SIZE_BYTES_W = 13;
   localparam int GRANULE_W    = SIZE_BYTES_W - 1;
   localparam int ADDR_W       = 32;
   localparam int STATUS_W     = 2;

   localparam logic OPCODE_ALLOC = 1'b0;
   localparam logic OPCODE_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_CHECK,
      ST_APPEND,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/core/first_fit_heap_allocator.sv =====
// first fit heap allocator over an implicit list of block headers
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid / req_stall | req_opcode, req_alloc_size, req_free_address
//  rsp     | out       | rsp_valid / rsp_stall | rsp_data_address, rsp_status
//  csr     | in        | csr_valid / csr_ready | csr_heap_base
//
// one item at a time; the header memory walk visits each block with a read issue,
// then a check, until it finds a fitting block or the free target, or runs out;
// a free first decodes its address, and an allocate with no fit appends a block.
// a zero size allocate goes straight to the response; a bad free after the decode.
// synchronous active-high reset empties the heap; header memory is not cleared.
// a result waits in the output register under rsp_stall; the next item starts
// only after its result has moved there.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator #(
   parameter int HEAP_GRANULES   = ffha_pkg::HEAP_GRANULES_DEF,
   parameter int HEADER_GRANULES = ffha_pkg::HEADER_GRANULES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [ffha_pkg::SIZE_BYTES_W-1:0] req_alloc_size,
   input  logic [ffha_pkg::ADDR_W-1:0]     req_free_address,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ffha_pkg::ADDR_W-1:0]     rsp_data_address,
   output logic [ffha_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ffha_pkg::ADDR_W-1:0]     csr_heap_base
);
   import ffha_pkg::*;

   localparam int IDX_W   = $clog2(HEAP_GRANULES);
   localparam int END_W   = $clog2(HEAP_GRANULES + 1);
   localparam int ENTRY_W = END_W + 1;
   localparam int SUM_W   = ((END_W > GRANULE_W) ? END_W : GRANULE_W) + 2;
   localparam int GOFF_W  = ADDR_W - 2;

   localparam logic [SUM_W-1:0]  HDR_SUM    = SUM_W'(HEADER_GRANULES);
   localparam logic [SUM_W-1:0]  HEAP_LIMIT = SUM_W'(HEAP_GRANULES);
   localparam logic [GOFF_W-1:0] HDR_GOFF   = GOFF_W'(HEADER_GRANULES);

   // header memory: msb is the in-use flag, the rest the data size in granules
   logic [ENTRY_W-1:0] hdr_mem [HEAP_GRANULES];

   state_type state_ff, state_in;

   logic                 op_ff, op_in;
   logic [GRANULE_W-1:0] gran_ff, gran_in;
   logic [ADDR_W-1:0]    off_ff, off_in;
   logic [END_W-1:0]     target_ff, target_in;
   logic [END_W-1:0]     cur_ff, cur_in;
   logic [END_W-1:0]     end_ff, end_in;
   logic [ADDR_W-1:0]    base_ff;
   logic [ENTRY_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   logic                 req_accept;
   logic [SIZE_BYTES_W:0] size_round;
   logic                 rd_in_use;
   logic [END_W-1:0]     rd_size;
   logic [SUM_W-1:0]     next_sum;
   logic                 fits;
   logic [SUM_W-1:0]     append_sum;
   logic                 no_space;
   logic [END_W-1:0]     addr_gran;
   logic [ADDR_W-1:0]    block_addr;
   logic [GOFF_W-1:0]    free_goff;
   logic [GOFF_W-1:0]    free_hdr;
   logic                 free_ok;
   logic                 rsp_slot_free;

   assign req_accept    = req_valid && !req_stall;
   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_address = rsp_addr_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;

   // request rounded up to whole granules
   assign size_round = {1'b0, req_alloc_size} + (SIZE_BYTES_W + 1)'(3);

   assign rd_in_use  = rd_data_ff[END_W];
   assign rd_size    = rd_data_ff[END_W-1:0];
   assign next_sum   = SUM_W'(cur_ff) + HDR_SUM + SUM_W'(rd_size);
   assign fits       = !rd_in_use && (SUM_W'(rd_size) >= SUM_W'(gran_ff));
   assign append_sum = SUM_W'(end_ff) + HDR_SUM + SUM_W'(gran_ff);
   assign no_space   = (append_sum > HEAP_LIMIT);

   assign addr_gran  = (state_ff == ST_APPEND) ? end_ff : cur_ff;
   assign block_addr = base_ff + (ADDR_W'(SUM_W'(addr_gran) + HDR_SUM) << 2);

   // free address checks: aligned, past the first header, below the heap end
   assign free_goff = off_ff[ADDR_W-1:2];
   assign free_hdr  = free_goff - HDR_GOFF;
   assign free_ok   = (off_ff[1:0] == 2'b00) && (free_goff >= HDR_GOFF)
                      && (free_hdr < GOFF_W'(end_ff));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hdr_mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= hdr_mem[cur_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_opcode == OPCODE_FREE) begin
                  state_in = ST_DECODE;
               end else if (req_alloc_size == '0) begin
                  state_in = ST_RESP;
               end else if (end_ff == '0) begin
                  state_in = ST_APPEND;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_DECODE: begin
            state_in = free_ok ? ST_READ : ST_RESP;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (op_ff == OPCODE_FREE) begin
               if (cur_ff == target_ff) begin
                  state_in = ST_RESP;
               end else if (next_sum <= SUM_W'(target_ff)) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_RESP;
               end
            end else if (fits) begin
               state_in = ST_RESP;
            end else if (next_sum < SUM_W'(end_ff)) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      gran_in       = gran_ff;
      off_in        = off_ff;
      target_in     = target_ff;
      cur_in        = cur_ff;
      end_in        = end_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_ff[IDX_W-1:0];
      mem_wdata     = rd_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in         = req_opcode;
               gran_in       = size_round[SIZE_BYTES_W:2];
               off_in        = req_free_address - base_ff;
               cur_in        = '0;
               res_addr_in   = '0;
               res_status_in = STATUS_OK;
               if (req_opcode == OPCODE_ALLOC && req_alloc_size == '0) begin
                  res_status_in = STATUS_ZERO_SIZE;
               end
            end
         end
         ST_DECODE: begin
            target_in = END_W'(free_hdr);
         end
         ST_READ: begin
         end
         ST_CHECK: begin
            if (op_ff == OPCODE_FREE) begin
               if (cur_ff == target_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = {1'b0, rd_size};
                  // freeing the last block pulls the heap end back
                  if (next_sum == SUM_W'(end_ff)) begin
                     end_in = target_ff;
                  end
               end else begin
                  cur_in = END_W'(next_sum);
               end
            end else if (fits) begin
               mem_we      = 1'b1;
               mem_wdata   = {1'b1, rd_size};
               res_addr_in = block_addr;
            end else begin
               cur_in = END_W'(next_sum);
            end
         end
         ST_APPEND: begin
            if (no_space) begin
               res_status_in = STATUS_NO_SPACE;
            end else begin
               mem_we      = 1'b1;
               mem_waddr   = end_ff[IDX_W-1:0];
               mem_wdata   = {1'b1, END_W'(gran_ff)};
               end_in      = END_W'(append_sum);
               res_addr_in = block_addr;
            end
         end
         ST_RESP: begin
            if (rsp_slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         end_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            base_ff <= csr_heap_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      gran_ff       <= gran_in;
      off_ff        <= off_in;
      target_ff     <= target_in;
      cur_ff        <= cur_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   `FFHA_ASSERT_NEXT(a_zero_size_answer, clock, reset, (req_accept && req_opcode == OPCODE_ALLOC && req_alloc_size == '0), (state_ff == ST_RESP && res_status_ff == STATUS_ZERO_SIZE))
   `FFHA_ASSERT_NEXT(a_end_only_on_update, clock, reset, (state_ff != ST_CHECK && state_ff != ST_APPEND), $stable(end_ff))
   `FFHA_ASSERT_IMPLIES(a_fail_has_no_address, clock, reset, (rsp_valid && rsp_status != STATUS_OK), (rsp_data_address == '0))

endmodule
